### design/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        M_IDLE,
        M_SKIP,
        M_STR,
        M_ESC,
        M_HEXA,
        M_BSL,
        M_UCH,
        M_HEXB
    } t_mode;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN    = 4'd1;
    localparam logic [3:0] ERR_UNTERM_STR = 4'd2;
    localparam logic [3:0] ERR_RAW_CTRL   = 4'd3;
    localparam logic [3:0] ERR_UNTERM_ESC = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd5;
    localparam logic [3:0] ERR_TRUNC_HEX  = 4'd6;
    localparam logic [3:0] ERR_BAD_HEX    = 4'd7;
    localparam logic [3:0] ERR_LONE_HIGH  = 4'd8;
    localparam logic [3:0] ERR_BAD_LOW    = 4'd9;
    localparam logic [3:0] ERR_LONE_LOW   = 4'd10;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Surrogate prefixes (top six bits of a 16-bit unit)
    localparam logic [5:0] HIGH_SUR_TOP = 6'b110110;
    localparam logic [5:0] LOW_SUR_TOP  = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // Queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One front-to-back request: a code point to encode, a raw byte, a close or an error
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  code;
        logic        raw;
        logic [20:0] cp;
    } t_req;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Index of the last UTF-8 byte for a code point (byte count minus one)
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp <= 21'h7F) begin
            r = 2'd0;
        end else if (cp <= 21'h7FF) begin
            r = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/jsu_front.sv
`default_nettype none
module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_end_flag,
    output jsu_pkg::t_req      o_req,
    output logic               o_push
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_high, n_high;

    logic [4:0]  dig;
    logic [15:0] hex_new;
    logic        hex_done;
    logic        is_hi, is_lo;
    logic [7:0]  esc_byte;
    logic        esc_ok;

    // Shared decode
    assign dig      = hex_val(i_text_byte);
    assign hex_new  = {r_hex[11:0], dig[3:0]};
    assign hex_done = (r_cnt == 2'd3);
    assign is_hi    = (hex_new[15:10] == HIGH_SUR_TOP);
    assign is_lo    = (hex_new[15:10] == LOW_SUR_TOP);

    // Simple escapes
    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = i_text_byte;
        case (i_text_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: esc_byte = i_text_byte;
            CH_B:    esc_byte = 8'h08;
            CH_F:    esc_byte = 8'h0C;
            CH_N:    esc_byte = 8'h0A;
            CH_R:    esc_byte = 8'h0D;
            CH_T:    esc_byte = 8'h09;
            default: esc_ok   = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_mode = r_mode;
        if (i_acc) begin
            if (i_end_flag) begin
                n_mode = M_IDLE;
            end else begin
                case (r_mode)
                    M_SKIP: if (i_text_byte == CH_QUOTE) n_mode = M_STR;
                    M_STR: begin
                        if (i_text_byte == CH_QUOTE)        n_mode = M_IDLE;
                        else if (i_text_byte < CTRL_LIMIT)  n_mode = M_SKIP;
                        else if (i_text_byte == CH_BSL)     n_mode = M_ESC;
                    end
                    M_ESC: begin
                        if (i_text_byte == CH_U) n_mode = M_HEXA;
                        else if (esc_ok)         n_mode = M_STR;
                        else                     n_mode = M_SKIP;
                    end
                    M_HEXA: begin
                        if (!dig[4])       n_mode = M_SKIP;
                        else if (hex_done) n_mode = is_hi ? M_BSL : (is_lo ? M_SKIP : M_STR);
                    end
                    M_HEXB: begin
                        if (!dig[4])       n_mode = M_SKIP;
                        else if (hex_done) n_mode = is_lo ? M_STR : M_SKIP;
                    end
                    M_BSL: n_mode = (i_text_byte == CH_BSL) ? M_UCH : M_SKIP;
                    M_UCH: n_mode = (i_text_byte == CH_U) ? M_HEXB : M_SKIP;
                    default: n_mode = (i_text_byte == CH_QUOTE) ? M_STR : M_SKIP;
                endcase
            end
        end
    end

    // Requests and hex datapath
    always_comb begin
        o_push = 1'b0;
        o_req  = '{kind: KIND_DATA, code: ERR_NONE, raw: 1'b1, cp: 21'd0};
        n_hex  = r_hex;
        n_cnt  = r_cnt;
        n_high = r_high;
        if (i_acc) begin
            if (i_end_flag) begin
                o_req.kind = KIND_ERR;
                o_push     = 1'b1;
                case (r_mode)
                    M_SKIP:         o_push     = 1'b0;
                    M_STR:          o_req.code = ERR_UNTERM_STR;
                    M_ESC:          o_req.code = ERR_UNTERM_ESC;
                    M_HEXA, M_HEXB: o_req.code = ERR_TRUNC_HEX;
                    M_BSL, M_UCH:   o_req.code = ERR_LONE_HIGH;
                    default:        o_req.code = ERR_NO_OPEN;
                endcase
            end else begin
                case (r_mode)
                    M_SKIP: o_push = 1'b0;
                    M_STR: begin
                        if (i_text_byte == CH_QUOTE) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_CLOSE;
                        end else if (i_text_byte < CTRL_LIMIT) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_RAW_CTRL;
                        end else if (i_text_byte != CH_BSL) begin
                            o_push   = 1'b1;
                            o_req.cp = {13'd0, i_text_byte};
                        end
                    end
                    M_ESC: begin
                        if (i_text_byte == CH_U) begin
                            n_hex = 16'd0;
                            n_cnt = 2'd0;
                        end else if (esc_ok) begin
                            o_push   = 1'b1;
                            o_req.cp = {13'd0, esc_byte};
                        end else begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_BAD_ESC;
                        end
                    end
                    M_HEXA, M_HEXB: begin
                        if (!dig[4]) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_BAD_HEX;
                        end else begin
                            n_hex = hex_new;
                            n_cnt = r_cnt + 2'd1;
                            if (hex_done) begin
                                o_req.raw = 1'b0;
                                if (r_mode == M_HEXA) begin
                                    if (is_hi) begin
                                        n_high = hex_new[9:0];
                                    end else if (is_lo) begin
                                        o_push     = 1'b1;
                                        o_req.kind = KIND_ERR;
                                        o_req.code = ERR_LONE_LOW;
                                    end else begin
                                        o_push   = 1'b1;
                                        o_req.cp = {5'd0, hex_new};
                                    end
                                end else if (is_lo) begin
                                    o_push   = 1'b1;
                                    o_req.cp = {1'b0, r_high, hex_new[9:0]} + SUPP_BASE;
                                end else begin
                                    o_push     = 1'b1;
                                    o_req.kind = KIND_ERR;
                                    o_req.code = ERR_BAD_LOW;
                                end
                            end
                        end
                    end
                    M_BSL: begin
                        if (i_text_byte != CH_BSL) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_LONE_HIGH;
                        end
                    end
                    M_UCH: begin
                        if (i_text_byte == CH_U) begin
                            n_hex = 16'd0;
                            n_cnt = 2'd0;
                        end else begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_LONE_HIGH;
                        end
                    end
                    default: begin
                        if (i_text_byte != CH_QUOTE) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_ERR;
                            o_req.code = ERR_NO_OPEN;
                        end
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hex  <= 16'd0;
            r_cnt  <= 2'd0;
            r_high <= 10'd0;
        end else begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_high <= n_high;
        end
    end

endmodule
`default_nettype wire

### design/jsu_queue.sv
`default_nettype none
module jsu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_req i_req,
    input  wire logic          i_pop,
    output jsu_pkg::t_req      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import jsu_pkg::*;

    t_req             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QDEPTH[QAW:0]);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### design/jsu_back.sv
`default_nettype none
module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsu_pkg::t_req i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_kind,
    output logic [3:0]         o_error_code,
    output logic               o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic [3:0] r_code;
    logic       r_last;
    logic [1:0] r_idx, n_idx;

    logic       load;
    logic [1:0] last_idx;
    logic [7:0] enc;
    logic [20:0] cp;

    assign cp   = i_head.cp;
    assign load = !r_valid || !i_out_stall;

    // Index of the last byte this request yields (byte count minus one)
    always_comb begin
        if (i_head.kind != KIND_DATA || i_head.raw) begin
            last_idx = 2'd0;
        end else begin
            last_idx = utf8_last_idx(cp);
        end
    end

    // UTF-8 byte for the current position
    always_comb begin
        enc = cp[7:0];
        if (i_head.kind != KIND_DATA) begin
            enc = 8'd0;
        end else if (!i_head.raw) begin
            case ({last_idx, r_idx})
                4'b0000: enc = {1'b0, cp[6:0]};
                4'b0100: enc = {3'b110, cp[10:6]};
                4'b0101: enc = {2'b10, cp[5:0]};
                4'b1000: enc = {4'b1110, cp[15:12]};
                4'b1001: enc = {2'b10, cp[11:6]};
                4'b1010: enc = {2'b10, cp[5:0]};
                4'b1100: enc = {5'b11110, cp[20:18]};
                4'b1101: enc = {2'b10, cp[17:12]};
                4'b1110: enc = {2'b10, cp[11:6]};
                4'b1111: enc = {2'b10, cp[5:0]};
                default: enc = 8'd0;
            endcase
        end
    end

    // Pop the request with its final byte
    assign o_pop = load && !i_empty && (r_idx == last_idx);
    always_comb begin
        n_idx = r_idx;
        if (load && !i_empty) begin
            n_idx = (r_idx == last_idx) ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (load) r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte <= enc;
            r_kind <= i_head.kind;
            r_code <= i_head.code;
            r_last <= (r_idx == last_idx);
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_kind       = r_kind;
    assign o_error_code = r_code;
    assign o_last       = r_last;

endmodule
`default_nettype wire

### design/json_string_unescape_utf8.sv
`default_nettype none
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+--------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_text_byte, i_end_flag
// out      | o_out_valid  | i_out_stall  | o_out_byte, o_kind, o_error_code, o_last
//
// One input byte is taken per cycle unless o_in_stall is high; each yields at most one request.
// Each request drains as 1 to 4 bytes via the output register, one per cycle when i_out_stall is low.
// A four-entry request queue absorbs multi-byte UTF-8 output; o_in_stall rises only when it is full.
// Reset (synchronous, active low) returns the parser to waiting for an opening quote.
module json_string_unescape_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_flag,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_error_code,
    output logic             o_last
);
    import jsu_pkg::*;

    t_req req, head;
    logic push, pop, q_empty, q_full, acc;

    assign o_in_stall = q_full;
    assign acc        = i_in_valid && !q_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_text_byte (i_text_byte),
        .i_end_flag  (i_end_flag),
        .o_req       (req),
        .o_push      (push)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue both full and empty");
    a_marker_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_DATA) |-> o_last)
        else $error("close or error not marked last");
    a_code_only_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_ERR) |-> (o_error_code == ERR_NONE))
        else $error("error code on non-error result");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> !q_empty)
        else $error("pushed request lost");
`endif

endmodule
`default_nettype wire
